@@ hdl/cptt_pkg.sv @@
// Shared types, codes and microcode table of the clip playback time tracker.
package cptt_pkg;

   // Fixed field widths
   localparam int DUR_W    = 32;
   localparam int SPEED_W  = 16;
   localparam int DELTA_W  = 20;
   localparam int REQ_W    = 2;
   localparam int PROD_W   = DELTA_W + SPEED_W;
   localparam int POS_W    = 32;
   localparam int NORM_BITS = 16;
   localparam int NORM_W   = NORM_BITS + 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_FRAC_BITS = 24;

   localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << NORM_BITS;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_START = 2'd1;
   localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP     = 2'd2;

   // Microcode steps
   typedef logic [2:0] step_type;
   localparam step_type STEP_WAIT      = 3'd0;
   localparam step_type STEP_MUL       = 3'd1;
   localparam step_type STEP_EXEC      = 3'd2;
   localparam step_type STEP_MOD_STEP  = 3'd3;
   localparam step_type STEP_MOD_FIN   = 3'd4;
   localparam step_type STEP_NORM_INIT = 3'd5;
   localparam step_type STEP_NORM_STEP = 3'd6;
   localparam step_type STEP_OUT       = 3'd7;

   typedef enum logic [2:0] {
      UOP_ACCEPT,
      UOP_MUL,
      UOP_EXEC,
      UOP_MOD_STEP,
      UOP_MOD_FIN,
      UOP_NORM_INIT,
      UOP_NORM_STEP,
      UOP_LOAD_OUT
   } uop_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_NEED_MOD,
      COND_MORE,
      COND_NORM_DIV,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic     ready;
      uop_type  uop;
      cond_type cond;
      step_type target;
      step_type alt;
   } uword_type;

   typedef struct packed {
      logic accept;
      logic need_mod;
      logic more;
      logic norm_div;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [DUR_W-1:0]          duration;
      logic signed [SPEED_W-1:0] speed;
      logic                      loop_mode;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [NORM_W-1:0] normalized;
      logic              playing;
      logic              finished;
      logic              looped;
   } result_type;

   // Control store: taken condition jumps to target, otherwise to alt
   localparam uword_type UCODE [8] = '{
      '{1'b1, UOP_ACCEPT,    COND_ACCEPT,   STEP_MUL,       STEP_WAIT},
      '{1'b0, UOP_MUL,       COND_ALWAYS,   STEP_EXEC,      STEP_EXEC},
      '{1'b0, UOP_EXEC,      COND_NEED_MOD, STEP_MOD_STEP,  STEP_NORM_INIT},
      '{1'b0, UOP_MOD_STEP,  COND_MORE,     STEP_MOD_STEP,  STEP_MOD_FIN},
      '{1'b0, UOP_MOD_FIN,   COND_ALWAYS,   STEP_NORM_INIT, STEP_NORM_INIT},
      '{1'b0, UOP_NORM_INIT, COND_NORM_DIV, STEP_NORM_STEP, STEP_OUT},
      '{1'b0, UOP_NORM_STEP, COND_MORE,     STEP_NORM_STEP, STEP_OUT},
      '{1'b0, UOP_LOAD_OUT,  COND_OUT_FREE, STEP_WAIT,      STEP_OUT}
   };

endpackage

@@ hdl/cptt_sequencer.sv @@
// Microcode step counter and control store of the clip playback time tracker.
module cptt_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  cptt_pkg::status_type status,
   output cptt_pkg::uword_type  ctrl
);
   import cptt_pkg::*;

   step_type step_ff, step_in;
   logic     taken;

   assign ctrl = UCODE[step_ff];

   always_comb begin
      unique case (ctrl.cond)
         COND_ALWAYS:   taken = 1'b1;
         COND_ACCEPT:   taken = status.accept;
         COND_NEED_MOD: taken = status.need_mod;
         COND_MORE:     taken = status.more;
         COND_NORM_DIV: taken = status.norm_div;
         COND_OUT_FREE: taken = status.out_free;
         default:       taken = 1'b1;
      endcase
      step_in = taken ? ctrl.target : ctrl.alt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ hdl/cptt_datapath.sv @@
// Playback state, increment multiplier and shared restoring divider step.
module cptt_datapath #(
   parameter int TIME_WIDTH     = 32,
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cptt_pkg::uword_type            ctrl,
   input  logic                           accept,
   input  logic [cptt_pkg::REQ_W-1:0]     req_type,
   input  logic [cptt_pkg::DELTA_W-1:0]   tick_delta,
   input  cptt_pkg::cfg_type              cfg,
   output logic                           need_mod,
   output logic                           more,
   output logic                           norm_div,
   output cptt_pkg::result_type           result
);
   import cptt_pkg::*;

   localparam int TW         = TIME_WIDTH;
   localparam int PROD_SHIFT = PROD_FRAC_BITS - TIME_FRAC_BITS;
   localparam int SUM_W      = ((TW > PROD_W) ? TW : PROD_W) + 2;
   localparam int MAG_W      = SUM_W - 1;
   localparam int CNT_W      = $clog2(MAG_W + 1);
   localparam int CW         = (TW > DUR_W) ? TW : DUR_W;
   localparam logic [TW-1:0] TIME_MAX = '1;

   // Latched request
   logic [REQ_W-1:0]   req_ff;
   logic [DELTA_W-1:0] delta_ff;

   // Playback state
   logic [TW-1:0] cur_ff;
   logic          play_ff, loaded_ff, fin_rep_ff;
   logic          fin_ff, looped_ff;

   // Working registers
   logic signed [PROD_W-1:0] inc_ff;
   logic [TW-1:0]            rem_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic                     neg_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [NORM_W-1:0]        norm_ff;

   logic signed [DELTA_W:0]  delta_s;
   logic signed [PROD_W-1:0] prod;
   logic [CW-1:0]            dur_wide;
   logic [TW-1:0]            dur;
   logic signed [SUM_W-1:0]  sum, dur_ext, max_ext, neg_sum;
   logic                     tick_go, sum_neg, sum_ge;
   logic                     shift_bit, step_ge;
   logic [TW:0]              trial, trial_sub;
   logic [TW-1:0]            rem_next;

   assign delta_s = signed'({1'b0, delta_ff});
   assign prod    = delta_s * cfg.speed;

   // Clamp the register to the largest time
   assign dur_wide = CW'(cfg.duration);
   assign dur      = (dur_wide > CW'(TIME_MAX)) ? TIME_MAX : dur_wide[TW-1:0];

   assign sum     = signed'(SUM_W'(cur_ff)) + SUM_W'(inc_ff);
   assign dur_ext = signed'(SUM_W'(dur));
   assign max_ext = signed'(SUM_W'(TIME_MAX));
   assign neg_sum = -sum;
   assign sum_neg = sum[SUM_W-1];
   assign sum_ge  = (sum >= dur_ext);
   assign tick_go = (req_ff == REQ_TICK) && play_ff && loaded_ff;

   assign need_mod = tick_go && cfg.loop_mode && (dur != '0) && (sum_ge || sum_neg);
   assign more     = (cnt_ff > CNT_W'(1));
   assign norm_div = loaded_ff && (dur != '0) && (cur_ff < dur);

   // Restoring divider step, shared by the wrap modulo and the normalisation
   assign shift_bit = (ctrl.uop == UOP_MOD_STEP) ? mag_ff[MAG_W-1] : 1'b0;
   assign trial     = {rem_ff, shift_bit};
   assign trial_sub = trial - {1'b0, dur};
   assign step_ge   = (trial >= {1'b0, dur});
   assign rem_next  = step_ge ? trial_sub[TW-1:0] : trial[TW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= '0;
         play_ff    <= 1'b0;
         loaded_ff  <= 1'b0;
         fin_rep_ff <= 1'b0;
      end else begin
         case (ctrl.uop)
            UOP_ACCEPT: begin
               if (accept) begin
                  req_ff   <= req_type;
                  delta_ff <= tick_delta;
               end
            end
            UOP_MUL: begin
               inc_ff <= prod >>> PROD_SHIFT;
            end
            UOP_EXEC: begin
               fin_ff    <= tick_go && !cfg.loop_mode && (sum_ge || sum_neg) && !fin_rep_ff;
               looped_ff <= tick_go && cfg.loop_mode && (dur != '0) && (sum_ge || sum_neg);
               neg_ff    <= sum_neg;
               mag_ff    <= sum_neg ? neg_sum[MAG_W-1:0] : sum[MAG_W-1:0];
               rem_ff    <= '0;
               cnt_ff    <= CNT_W'(MAG_W);
               if (req_ff == REQ_START) begin
                  loaded_ff  <= 1'b1;
                  play_ff    <= 1'b1;
                  cur_ff     <= '0;
                  fin_rep_ff <= 1'b0;
               end else if (req_ff == REQ_STOP) begin
                  loaded_ff  <= 1'b0;
                  play_ff    <= 1'b0;
                  cur_ff     <= '0;
                  fin_rep_ff <= 1'b0;
               end else if (tick_go) begin
                  if (!cfg.loop_mode) begin
                     if (sum_ge || sum_neg) begin
                        cur_ff     <= sum_neg ? '0 : dur;
                        play_ff    <= 1'b0;
                        fin_rep_ff <= 1'b1;
                     end else begin
                        cur_ff <= sum[TW-1:0];
                     end
                  end else if (dur != '0) begin
                     if (!(sum_ge || sum_neg)) begin
                        cur_ff <= sum[TW-1:0];
                     end
                  end else begin
                     if (sum_neg) begin
                        cur_ff <= '0;
                     end else if (sum > max_ext) begin
                        cur_ff <= TIME_MAX;
                     end else begin
                        cur_ff <= sum[TW-1:0];
                     end
                  end
               end
            end
            UOP_MOD_STEP: begin
               rem_ff <= rem_next;
               mag_ff <= {mag_ff[MAG_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - CNT_W'(1);
            end
            UOP_MOD_FIN: begin
               if (!neg_ff) begin
                  cur_ff <= rem_ff;
               end else begin
                  cur_ff <= (rem_ff != '0) ? dur - rem_ff : '0;
               end
            end
            UOP_NORM_INIT: begin
               rem_ff <= cur_ff;
               cnt_ff <= CNT_W'(NORM_BITS);
               if (!loaded_ff || (dur == '0)) begin
                  norm_ff <= '0;
               end else if (cur_ff >= dur) begin
                  norm_ff <= NORM_ONE;
               end else begin
                  norm_ff <= '0;
               end
            end
            UOP_NORM_STEP: begin
               rem_ff  <= rem_next;
               norm_ff <= {norm_ff[NORM_W-2:0], step_ge};
               cnt_ff  <= cnt_ff - CNT_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.position   = POS_W'(cur_ff);
      result.normalized = norm_ff;
      result.playing    = play_ff && loaded_ff;
      result.finished   = fin_ff;
      result.looped     = looped_ff;
   end

endmodule

@@ hdl/clip_playback_time_tracker.sv @@
// Top level of the clip playback time tracker: ports, registers, result stage.
//
//  channel  | direction | words              | payload
//  ---------+-----------+--------------------+--------------------------------------
//  req_     | in        | one per request    | tuser: req_type; tdata: tick_delta
//  rsp_     | out       | one per request    | tdata: position, normalised, flags
//  csr_     | in        | one per write      | index, data (no read-back)
//
//  A request runs from acceptance to a loaded result through accept, multiply,
//  update, normalisation init, 16 divider steps and load; the divider steps are skipped
//  when no division runs (no clip, zero duration or at the end). A looping wrap adds
//  restoring steps and a fix-up on the divider shared with normalisation.
//  Synchronous active-high reset clears playback; registers take speed 1.0, one-shot.
//  A request is taken while the last result waits; the load step holds while that is full.
module clip_playback_time_tracker #(
   parameter int TIME_WIDTH     = 32,
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // [19:0] tick_delta
   input  logic [cptt_pkg::REQ_W-1:0]        req_tuser,  // [1:0] req_type
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] position, [48:32] normalized_position, [49] playing,
   // [50] finished_event, [51] looped_event
   output logic [55:0]                       rsp_tdata,
   // Register write port
   input  logic                              csr_we,
   input  logic [cptt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cptt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cptt_pkg::*;

   uword_type  ctrl;
   status_type status;
   cfg_type    cfg_ff;
   result_type result, rsp_ff;
   logic       rsp_valid_ff;
   logic       need_mod, more, norm_div;
   logic       accept, out_free;

   // Handshake: accept only in the wait step, result stage frees on take
   assign req_tready = ctrl.ready;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      status.accept   = accept;
      status.need_mod = need_mod;
      status.more     = more;
      status.norm_div = norm_div;
      status.out_free = out_free;
   end

   cptt_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   cptt_datapath #(
      .TIME_WIDTH     (TIME_WIDTH),
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .accept     (accept),
      .req_type   (req_tuser),
      .tick_delta (req_tdata[DELTA_W-1:0]),
      .cfg        (cfg_ff),
      .need_mod   (need_mod),
      .more       (more),
      .norm_div   (norm_div),
      .result     (result)
   );

   // Configuration registers; a write to an unused index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duration  <= '0;
         cfg_ff.speed     <= SPEED_W'(256);
         cfg_ff.loop_mode <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DURATION: cfg_ff.duration  <= csr_wdata[DUR_W-1:0];
            CSR_SPEED:    cfg_ff.speed     <= signed'(csr_wdata[SPEED_W-1:0]);
            CSR_LOOP:     cfg_ff.loop_mode <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Output register: hold the word until taken, load when the sequencer
   // reaches the result step and the stage is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((ctrl.uop == UOP_LOAD_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((ctrl.uop == UOP_LOAD_OUT) && out_free) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.looped, rsp_ff.finished, rsp_ff.playing,
                        rsp_ff.normalized, rsp_ff.position};

`ifndef SYNTHESIS
   a_events_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.finished && rsp_ff.looped))
      else $error("finished and looped pulses given together");

   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.finished) |-> !rsp_ff.playing)
      else $error("finished pulse while still playing");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.normalized <= NORM_ONE))
      else $error("normalised position above one");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while the previous one is in progress");
`endif

endmodule

@@ test/clip_playback_time_tracker_tb.sv @@
// Self-checking testbench for the clip playback time tracker: directed and random requests.
module clip_playback_time_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cptt_pkg::*;

   // Request code that the block must ignore while still answering
   localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

   // Product of delta (Q4.16) and speed (Q8.8) carries 24 fraction bits
   localparam int PRODUCT_SHIFT = PROD_FRAC_BITS - 16;

   localparam int RANDOM_ITEMS  = 750;
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int STALL_LIMIT   = 4000;  // cycles without any accepted word
   localparam int SETTLE_CYCLES = 80;    // margin for the worst item, one with a wrap
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [REQ_W-1:0]   kind;
      logic [DELTA_W-1:0] delta;
   } clip_request_type;

   // Block ports; every input starts at a known value
   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata  = '0;   // [19:0] tick_delta
   logic [REQ_W-1:0]      req_tuser  = REQ_TICK;  // [1:0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] position, [48:32] normalized_position, [49] playing,
   // [50] finished_event, [51] looped_event
   logic [55:0]           rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_DURATION;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Mirror of the registers, at their reset values
   logic [DUR_W-1:0]          reg_duration = '0;
   logic signed [SPEED_W-1:0] reg_speed    = 16'sd256;
   logic                      reg_loop     = 1'b0;

   // Mirror of the playback state
   logic [POS_W-1:0] play_time     = '0;
   logic             play_running  = 1'b0;
   logic             clip_present  = 1'b0;
   logic             finish_told   = 1'b0;

   clip_request_type request_backlog[$];
   result_type       due_playheads[$];

   int  words_sent      = 0;
   int  results_checked = 0;
   int  fault_count     = 0;
   int  settings_used   = 0;
   int  finish_pulses   = 0;
   int  wrap_pulses     = 0;
   int  hold_asked      = 0;
   int  hold_taken      = 0;
   int  hold_left       = 0;
   int  gap_left        = 0;
   int  stall_left      = 0;
   int  idle_cycles     = 0;
   int  draw;
   bit  no_idle         = 1'b0;

   clip_request_type next_request;
   result_type       predicted;
   result_type       observed;
   result_type       wanted;

   clip_playback_time_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Work out the result of one accepted request and advance the mirrored state.
   function automatic result_type advance_playhead(input logic [REQ_W-1:0] kind,
                                                   input logic [DELTA_W-1:0] delta);
      result_type outcome;
      longint     step;
      longint     total;
      longint     span;
      longint     rem;
      outcome = '0;
      span = longint'(reg_duration);
      case (kind)
         REQ_START: begin
            clip_present = 1'b1;
            play_running = 1'b1;
            play_time    = '0;
            finish_told  = 1'b0;
         end
         REQ_STOP: begin
            clip_present = 1'b0;
            play_running = 1'b0;
            play_time    = '0;
            finish_told  = 1'b0;
         end
         REQ_TICK: begin
            if (play_running && clip_present) begin
               // exact signed product, floored down to the time format
               step  = (longint'(delta) * longint'(reg_speed)) >>> PRODUCT_SHIFT;
               total = longint'(play_time) + step;
               if (!reg_loop) begin
                  if (total >= span || total < 0) begin
                     play_time    = (total < 0) ? '0 : reg_duration;
                     play_running = 1'b0;
                     if (!finish_told) begin
                        finish_told      = 1'b1;
                        outcome.finished = 1'b1;
                     end
                  end else begin
                     play_time = POS_W'(total);
                  end
               end else if (span > 0) begin
                  outcome.looped = (total >= span) || (total < 0);
                  if (total >= 0) begin
                     play_time = POS_W'(total % span);
                  end else begin
                     rem = (-total) % span;
                     play_time = (rem != 0) ? POS_W'(span - rem) : '0;
                  end
               end else begin
                  // looping with no length: saturate to the time range
                  if (total < 0)
                     play_time = '0;
                  else if (total > longint'(32'hFFFF_FFFF))
                     play_time = 32'hFFFF_FFFF;
                  else
                     play_time = POS_W'(total);
               end
            end
         end
         default: ;  // spare code: state reported unchanged
      endcase
      outcome.position = play_time;
      if (!clip_present || reg_duration == 0)
         outcome.normalized = '0;
      else if (play_time >= reg_duration)
         outcome.normalized = NORM_ONE;
      else
         outcome.normalized = NORM_W'((longint'(play_time) << NORM_BITS) / span);
      outcome.playing = play_running && clip_present;
      return outcome;
   endfunction

   // Request driver: present the backlog, with a drawn gap after each word
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = advance_playhead(req_tuser, req_tdata[DELTA_W-1:0]);
            due_playheads.push_back(predicted);
            if (predicted.finished)
               finish_pulses++;
            if (predicted.looped)
               wrap_pulses++;
         end
         // only touch the channel when no word is waiting for acceptance
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               next_request = request_backlog.pop_front();
               req_tuser    <= next_request.kind;
               req_tdata    <= {4'b0000, next_request.delta};
               req_tvalid   <= 1'b1;
               gap_left     <= no_idle ? 0 : $urandom_range(0, 3);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Count a fault; report only the first few in full
   function automatic bit note_fault();
      fault_count++;
      return fault_count <= REPORT_LIMIT;
   endfunction

   // Result monitor: check each word against the oldest prediction, and pace tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            observed.position   = rsp_tdata[31:0];
            observed.normalized = rsp_tdata[48:32];
            observed.playing    = rsp_tdata[49];
            observed.finished   = rsp_tdata[50];
            observed.looped     = rsp_tdata[51];
            if (due_playheads.size() == 0) begin
               if (note_fault())
                  $display("result word %0d arrived with no request outstanding: %h",
                           results_checked, rsp_tdata);
            end else begin
               wanted = due_playheads.pop_front();
               if (observed !== wanted) begin
                  if (note_fault())
                     $display({"mismatch on word %0d (expected/actual): position %h/%h ",
                               "norm %h/%h playing %b/%b finished %b/%b looped %b/%b"},
                              results_checked, wanted.position, observed.position,
                              wanted.normalized, observed.normalized,
                              wanted.playing, observed.playing,
                              wanted.finished, observed.finished,
                              wanted.looped, observed.looped);
               end
            end
         end
         // a requested hold-off takes priority; it lets the block fill up
         if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            // draw the wait before the next word
            draw = no_idle ? 0 : $urandom_range(0, 3);
            rsp_tready <= (draw == 0);
            stall_left <= (draw == 0) ? 0 : draw - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: give up when no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", idle_cycles);
         $display("clip_playback_time_tracker_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [DELTA_W-1:0] delta);
      clip_request_type item;
      item.kind  = kind;
      item.delta = delta;
      request_backlog.push_back(item);
      words_sent++;
   endtask

   // Wait until every request sent so far has had its result checked
   task automatic drain();
      while (results_checked != words_sent)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_DURATION: reg_duration = value;
         CSR_SPEED:    reg_speed    = value[SPEED_W-1:0];
         CSR_LOOP:     reg_loop     = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Change the setting only once the block is idle; unused upper bits carry noise
   task automatic apply_setting(input logic [DUR_W-1:0] duration,
                                input logic [SPEED_W-1:0] speed,
                                input logic loop_on);
      drain();
      write_register(CSR_DURATION, duration);
      write_register(CSR_SPEED, {16'($urandom), speed});
      write_register(CSR_LOOP, {31'($urandom), loop_on});
      settings_used++;
   endtask

   function automatic logic [DUR_W-1:0] pick_duration();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2:       return DUR_W'($urandom_range(1, 16));
         3, 4:    return DUR_W'($urandom_range(32'h100, 32'h8_0000));
         5:       return DUR_W'($urandom_range(32'h8_0000, 32'h100_0000));
         default: return DUR_W'($urandom);
      endcase
   endfunction

   function automatic logic [SPEED_W-1:0] pick_speed();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'h0100;
         4:       return 16'hFF00;
         5:       return SPEED_W'($urandom_range(0, 16'h0400));
         default: return SPEED_W'($urandom);
      endcase
   endfunction

   function automatic logic [DELTA_W-1:0] pick_delta();
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return 20'hFFFFF;
         2, 3, 4:    return DELTA_W'($urandom);
         default:    return DELTA_W'($urandom_range(0, 20'h3FFF));
      endcase
   endfunction

   // Stimulus and end of run
   initial begin
      int                 random_sent;
      int                 phase_no;
      int                 run_len;
      int                 roll;
      bit                 climb;
      logic [REQ_W-1:0]   kind;
      random_sent = 0;
      phase_no    = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: no length, unit speed, one-shot. Tick while unloaded,
      // then a zero-length clip ends on its first tick.
      queue_request(REQ_TICK, 20'h12345);
      queue_request(REQ_START, 20'h00000);
      queue_request(REQ_TICK, 20'h00000);
      queue_request(REQ_TICK, 20'hFFFFF);
      queue_request(REQ_SPARE, 20'hFFFFF);
      queue_request(REQ_STOP, 20'hABCDE);

      // Three seconds one-shot: run through, clamp at the end, restart, unload
      apply_setting(32'h0003_0000, 16'h0100, 1'b0);
      queue_request(REQ_START, 20'h00000);
      queue_request(REQ_TICK, 20'h10000);
      queue_request(REQ_TICK, 20'h18000);
      queue_request(REQ_TICK, 20'hFFFFF);
      queue_request(REQ_START, 20'h55555);
      queue_request(REQ_TICK, 20'h2FFFF);
      queue_request(REQ_STOP, 20'h00000);

      // Smallest negative speed: one tick floors below zero and ends at zero
      apply_setting(32'h0003_0000, 16'hFFFF, 1'b0);
      queue_request(REQ_START, 20'h00000);
      queue_request(REQ_TICK, 20'h00001);
      queue_request(REQ_TICK, 20'h00001);

      // Looping at the speed extremes: wrap forwards, then backwards
      apply_setting(32'h0003_0000, 16'h7FFF, 1'b1);
      queue_request(REQ_START, 20'h00000);
      queue_request(REQ_TICK, 20'hFFFFF);
      queue_request(REQ_TICK, 20'h00000);
      apply_setting(32'h0003_0000, 16'h8000, 1'b1);
      queue_request(REQ_START, 20'h00000);
      queue_request(REQ_TICK, 20'hFFFFF);

      // Looping with no length saturates at zero
      apply_setting(32'h0000_0000, 16'h8000, 1'b1);
      queue_request(REQ_START, 20'h00000);
      queue_request(REQ_TICK, 20'hFFFFF);

      // Longest clip, fastest speed, one-shot
      apply_setting(32'hFFFF_FFFF, 16'h7FFF, 1'b0);
      queue_request(REQ_START, 20'h00000);
      queue_request(REQ_TICK, 20'hFFFFF);

      // Random phases: each a fresh setting, a start, then mostly ticks.
      // Two phases climb fast towards the top of the time range.
      while (random_sent < RANDOM_ITEMS) begin
         climb = (phase_no == 1 || phase_no == 4);
         if (climb)
            apply_setting((phase_no == 1) ? 32'h0 : 32'hFFFF_FFFF, 16'h7FFF,
                          (phase_no == 1) ? 1'b1 : 1'($urandom));
         else
            apply_setting(pick_duration(), pick_speed(), 1'($urandom));
         no_idle = ($urandom_range(0, 3) == 0);
         run_len = climb ? 50 : $urandom_range(20, 60);
         queue_request(REQ_START, DELTA_W'($urandom));
         for (int i = 0; i < run_len; i++) begin
            if (climb) begin
               queue_request(REQ_TICK, DELTA_W'($urandom_range(20'hC0000, 20'hFFFFF)));
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 84)
                  kind = REQ_TICK;
               else if (roll < 91)
                  kind = REQ_START;
               else if (roll < 96)
                  kind = REQ_STOP;
               else
                  kind = REQ_SPARE;
               queue_request(kind, pick_delta());
            end
         end
         random_sent += run_len + 1;
         // hold off the result side so the block fills and stalls its input
         if (phase_no == 2)
            hold_asked++;
         phase_no++;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d requests under %0d register settings, one long receiver hold",
               words_sent, settings_used);
      $display("results checked %0d, finish pulses %0d, wrap pulses %0d, faults %0d",
               results_checked, finish_pulses, wrap_pulses, fault_count);
      if (fault_count == 0 && due_playheads.size() == 0)
         $display("clip_playback_time_tracker_tb: clean");
      else
         $display("clip_playback_time_tracker_tb: errors");
      $finish;
   end

endmodule

@@ clip_playback_time_tracker.f @@
hdl/cptt_pkg.sv
hdl/cptt_sequencer.sv
hdl/cptt_datapath.sv
hdl/clip_playback_time_tracker.sv
test/clip_playback_time_tracker_tb.sv
